@@ rtl/stt_pkg.sv @@
package stt_pkg;

  localparam int unsigned MaxTimers = 16;
  localparam int unsigned SlotW = $clog2(MaxTimers);
  localparam int unsigned CntW = $clog2(MaxTimers + 1);
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    CMD_SET      = 3'd0,
    CMD_CLEAR    = 3'd1,
    CMD_PAUSE    = 3'd2,
    CMD_RESUME   = 3'd3,
    CMD_RESET    = 3'd4,
    CMD_QUERY    = 3'd5,
    CMD_CLEARALL = 3'd6,
    CMD_TICK     = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_FULL     = 3'd2,
    ST_FIRED    = 3'd3,
    ST_NONE     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TICK,
    S_SHIFT,
    S_EMIT
  } exec_state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] timer_id;
    logic [31:0] duration;
    logic        repeat_req;
    logic [31:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id_out;
    logic [31:0] time_left;
    logic        last;
  } out_item_t;

endpackage

@@ rtl/stt_queue.sv @@
module stt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  stt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_pop_i,
  output stt_pkg::in_item_t  out_data_o
);
  import stt_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  in_item_t              mem_q [QDepth];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [PtrW:0]         cnt_q;
  logic                  push, pop;

  assign in_stall_o  = (cnt_q == (PtrW+1)'(QDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_pop_i && out_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QDepth)) else $error("queue count overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count step");
`endif
endmodule

@@ rtl/stt_exec.sv @@
module stt_exec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  stt_pkg::in_item_t  cmd_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output stt_pkg::out_item_t out_o
);
  import stt_pkg::*;

  // Table storage; rows 0..cnt-1 are live, in creation order.
  logic [31:0] ident_q  [MaxTimers];
  logic [31:0] period_q [MaxTimers];
  logic [31:0] remain_q [MaxTimers];
  logic        rep_q    [MaxTimers];
  logic        pause_q  [MaxTimers];

  exec_state_e     st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [31:0]     next_id_q, next_id_d;
  logic            fired_q, fired_d;
  in_item_t        cur_q, cur_d;
  out_item_t       res_q, res_d;
  logic            res_v_q, res_v_d;
  out_item_t       pend_q, pend_d;   // latest fired beat of a tick, not yet issued

  logic [SlotW-1:0] ri, wi;
  logic             rd_hit, row_fire, row_keep;
  logic [31:0]      row_left;
  logic             out_free;

  assign ri = rd_q[SlotW-1:0];
  assign wi = wr_q[SlotW-1:0];
  assign out_free = !res_v_q || !out_stall_i;
  assign out_valid_o = res_v_q;
  assign out_o = res_q;

  assign row_fire = !pause_q[ri] && (cur_q.elapsed >= remain_q[ri]);
  assign row_keep = !row_fire || rep_q[ri];
  assign rd_hit   = (ident_q[ri] == cur_q.timer_id);
  assign row_left = row_fire ? period_q[ri] :
                    (pause_q[ri] ? remain_q[ri] : remain_q[ri] - cur_q.elapsed);

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; rd_d = rd_q; wr_d = wr_q;
    next_id_d = next_id_q; fired_d = fired_q; cur_d = cur_q;
    res_d = res_q; res_v_d = res_v_q && out_stall_i;
    pend_d = pend_q; cmd_pop_o = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          cur_d = cmd_i;
          rd_d = '0; wr_d = '0; fired_d = 1'b0;
          case (cmd_e'(cmd_i.cmd))
            CMD_SET: begin
              res_v_d = 1'b1;
              if (cnt_q == CntW'(MaxTimers)) begin
                res_d = '{status: ST_FULL, id_out: '0, time_left: '0, last: 1'b1};
              end else begin
                res_d = '{status: ST_OK, id_out: next_id_q, time_left: '0, last: 1'b1};
                cnt_d = cnt_q + 1'b1;
                next_id_d = next_id_q + 1'b1;
              end
            end
            CMD_CLEARALL: begin
              res_v_d = 1'b1;
              cnt_d = '0;
              res_d = '{status: ST_OK, id_out: cmd_i.timer_id, time_left: '0, last: 1'b1};
            end
            CMD_TICK: st_d = S_TICK;
            default: st_d = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (rd_q == cnt_q) begin
          res_d = '{status: ST_NOTFOUND, id_out: cur_q.timer_id, time_left: '0,
                    last: 1'b1};
          st_d = S_EMIT;
        end else if (rd_hit) begin
          res_d = '{status: ST_OK, id_out: cur_q.timer_id, time_left: '0, last: 1'b1};
          if (cmd_e'(cur_q.cmd) == CMD_QUERY) res_d.time_left = remain_q[ri];
          if (cmd_e'(cur_q.cmd) == CMD_CLEAR) begin
            wr_d = rd_q; rd_d = rd_q + 1'b1; st_d = S_SHIFT;
          end else begin
            st_d = S_EMIT;
          end
        end else begin
          rd_d = rd_q + 1'b1;
        end
      end
      S_SHIFT: begin
        if (rd_q == cnt_q) begin
          cnt_d = cnt_q - 1'b1; st_d = S_EMIT;
        end else begin
          rd_d = rd_q + 1'b1; wr_d = wr_q + 1'b1;
        end
      end
      S_TICK: begin
        if (rd_q == cnt_q) begin
          if (!fired_q) begin
            res_d = '{status: ST_NONE, id_out: '0, time_left: '0, last: 1'b1};
            st_d = S_EMIT;
          end else if (out_free) begin
            res_d = pend_q; res_d.last = 1'b1; res_v_d = 1'b1;
            cnt_d = wr_q; st_d = S_IDLE;
          end
        end else if (!row_fire) begin
          rd_d = rd_q + 1'b1; wr_d = wr_q + 1'b1;
        end else if (out_free) begin
          // The previous fired beat goes out as this one is found, so that the
          // final beat can still be marked last.
          if (fired_q) begin
            res_d = pend_q; res_v_d = 1'b1;
          end
          pend_d = '{status: ST_FIRED, id_out: ident_q[ri], time_left: '0, last: 1'b0};
          fired_d = 1'b1;
          rd_d = rd_q + 1'b1;
          if (row_keep) wr_d = wr_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          res_v_d = 1'b1; st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Table writes.
  logic tick_adv;
  assign tick_adv = (st_q == S_TICK) && (rd_q != cnt_q) && (!row_fire || out_free);

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && cmd_valid_i && out_free && cmd_e'(cmd_i.cmd) == CMD_SET &&
        cnt_q != CntW'(MaxTimers)) begin
      ident_q[cnt_q[SlotW-1:0]]  <= next_id_q;
      period_q[cnt_q[SlotW-1:0]] <= cmd_i.duration;
      remain_q[cnt_q[SlotW-1:0]] <= cmd_i.duration;
      rep_q[cnt_q[SlotW-1:0]]    <= cmd_i.repeat_req;
      pause_q[cnt_q[SlotW-1:0]]  <= 1'b0;
    end
    if (st_q == S_SCAN && rd_q != cnt_q && rd_hit) begin
      case (cmd_e'(cur_q.cmd))
        CMD_PAUSE:  pause_q[ri] <= 1'b1;
        CMD_RESUME: pause_q[ri] <= 1'b0;
        CMD_RESET:  remain_q[ri] <= period_q[ri];
        default: ;
      endcase
    end
    if (st_q == S_SHIFT && rd_q != cnt_q) begin
      ident_q[wi]  <= ident_q[ri];
      period_q[wi] <= period_q[ri];
      remain_q[wi] <= remain_q[ri];
      rep_q[wi]    <= rep_q[ri];
      pause_q[wi]  <= pause_q[ri];
    end
    if (tick_adv && row_keep) begin
      ident_q[wi]  <= ident_q[ri];
      period_q[wi] <= period_q[ri];
      remain_q[wi] <= row_left;
      rep_q[wi]    <= rep_q[ri];
      pause_q[wi]  <= pause_q[ri];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; rd_q <= '0; wr_q <= '0;
      next_id_q <= '0; fired_q <= 1'b0; res_v_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; rd_q <= rd_d; wr_q <= wr_d;
      next_id_q <= next_id_d; fired_q <= fired_d; res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    res_q  <= res_d;
    pend_q <= pend_d;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxTimers)) else $error("table count out of range");
  a_wr_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= rd_q) else $error("compaction write passed read");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> st_q == S_IDLE) else $error("command taken while busy");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && out_stall_i) |=> res_v_q && $stable(res_q)) else $error("result lost");
`endif
endmodule

@@ rtl/software_timer_table_top.sv @@
// Timer table of up to 16 timers in creation order. Commands enter a two-entry
// queue and are executed one at a time by a sequencer that walks the table one
// row per clock, except that a tick waits on a fired row while the output
// stalls. Set and clear all finish in the cycle that takes the command. An id
// lookup scans the table from row 0 in S_SCAN and issues its result from
// S_EMIT; a clear first compacts the rows behind the hit in S_SHIFT. A tick
// walks every row in S_TICK; each fired result is issued as the next one is
// found and the final one from S_TICK itself, or an ST_NONE result from S_EMIT
// when nothing fires. A new command is taken no earlier than the cycle in which
// the previous result is taken. Fired results are delivered in table order; the
// final result of each command carries last.
module software_timer_table_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  stt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output stt_pkg::out_item_t out_data_o
);
  import stt_pkg::*;

  in_item_t q_data;
  logic     q_valid, q_pop;

  stt_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o(q_valid), .out_pop_i(q_pop), .out_data_o(q_data)
  );

  stt_exec u_exec (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_pop_o(q_pop), .cmd_i(q_data),
    .out_valid_o, .out_stall_i, .out_o(out_data_o)
  );
endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stt_pkg::*;

  localparam int unsigned LimitCycles = 400000;

  class timer_table_sb;
    bit        used_q[MaxTimers];
    bit [31:0] ident_q[MaxTimers];
    bit [31:0] period_q[MaxTimers];
    bit [31:0] remain_q[MaxTimers];
    bit        rep_q[MaxTimers];
    bit        paused_q[MaxTimers];
    bit [31:0] next_id;
    out_item_t pending[$];
    int        errors;

    function int live_count();
      int n;
      n = 0;
      while (n < MaxTimers && used_q[n]) n++;
      return n;
    endfunction

    function void push(status_e st, bit [31:0] id, bit [31:0] tl, bit lst);
      out_item_t o;
      o.status = st;
      o.id_out = id;
      o.time_left = tl;
      o.last = lst;
      pending = {pending, o};
    endfunction

    function void move_slot(int d, int s);
      used_q[d] = used_q[s];
      ident_q[d] = ident_q[s];
      period_q[d] = period_q[s];
      remain_q[d] = remain_q[s];
      rep_q[d] = rep_q[s];
      paused_q[d] = paused_q[s];
    endfunction

    // Works out the results of one accepted command beat.
    function void note_command(in_item_t it);
      int n, idx, w, k;
      bit keep;
      n = live_count();
      idx = -1;
      case (cmd_e'(it.cmd))
        CMD_SET: begin
          if (n >= MaxTimers) begin
            push(ST_FULL, 0, 0, 1);
          end else begin
            used_q[n] = 1;
            ident_q[n] = next_id;
            period_q[n] = it.duration;
            remain_q[n] = it.duration;
            rep_q[n] = it.repeat_req;
            paused_q[n] = 0;
            push(ST_OK, next_id, 0, 1);
            next_id++;
          end
        end
        CMD_CLEARALL: begin
          for (int i = 0; i < MaxTimers; i++) used_q[i] = 0;
          push(ST_OK, it.timer_id, 0, 1);
        end
        CMD_TICK: begin
          w = 0;
          k = 0;
          for (int r = 0; r < n; r++) begin
            keep = 1;
            if (!paused_q[r]) begin
              if (it.elapsed >= remain_q[r]) begin
                push(ST_FIRED, ident_q[r], 0, 0);
                k++;
                if (rep_q[r]) remain_q[r] = period_q[r];
                else keep = 0;
              end else begin
                remain_q[r] -= it.elapsed;
              end
            end
            if (keep) begin
              if (w != r) move_slot(w, r);
              w++;
            end
          end
          for (int r = w; r < n; r++) used_q[r] = 0;
          if (k == 0) push(ST_NONE, 0, 0, 1);
          else pending[pending.size() - 1].last = 1;
        end
        default: begin
          for (int i = n - 1; i >= 0; i--) if (ident_q[i] == it.timer_id) idx = i;
          if (idx < 0) begin
            push(ST_NOTFOUND, it.timer_id, 0, 1);
          end else begin
            case (cmd_e'(it.cmd))
              CMD_CLEAR: begin
                for (int i = idx; i + 1 < n; i++) move_slot(i, i + 1);
                used_q[n - 1] = 0;
              end
              CMD_PAUSE:  paused_q[idx] = 1;
              CMD_RESUME: paused_q[idx] = 0;
              CMD_RESET:  remain_q[idx] = period_q[idx];
              default:    ;
            endcase
            push(ST_OK, it.timer_id,
                 (cmd_e'(it.cmd) == CMD_QUERY) ? remain_q[idx] : 32'd0, 1);
          end
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_o;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (got.status !== exp_o.status) begin
        $error("status: expected %0d, got %0d", exp_o.status, got.status);
        errors++;
      end
      if (got.id_out !== exp_o.id_out) begin
        $error("id_out: expected %0h, got %0h", exp_o.id_out, got.id_out);
        errors++;
      end
      if (got.time_left !== exp_o.time_left) begin
        $error("time_left: expected %0h, got %0h", exp_o.time_left, got.time_left);
        errors++;
      end
      if (got.last !== exp_o.last) begin
        $error("last: expected %0d, got %0d", exp_o.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b1;
  out_item_t out_data_o;

  timer_table_sb sb = new();
  int unsigned   cycles = 0;
  bit            calm;

  software_timer_table_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_command(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (cycles > LimitCycles) begin
      $display("software_timer_table_top: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !rst_ni || (!calm && $urandom_range(99) < 34);
  end

  // Drives one command beat, with a random gap in front of it.
  task automatic send_cmd(cmd_e c, bit [31:0] id, bit [31:0] dur, bit rep,
                          bit [31:0] el);
    in_item_t it;
    it.cmd = c;
    it.timer_id = id;
    it.duration = dur;
    it.repeat_req = rep;
    it.elapsed = el;
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  function automatic bit [31:0] pick_id();
    int n;
    n = sb.live_count();
    if (n > 0 && $urandom_range(99) < 80) return sb.ident_q[$urandom_range(n - 1)];
    if ($urandom_range(1)) return $urandom;
    return sb.next_id + $urandom_range(3);
  endfunction

  function automatic bit [31:0] pick_time();
    case ($urandom_range(5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(40);
    endcase
  endfunction

  initial begin
    calm = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty table, every command, extremes and zero periods.
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    send_cmd(CMD_QUERY, 32'hFFFF_FFFF, 0, 0, 0);
    send_cmd(CMD_SET, 0, 0, 1, 0);
    send_cmd(CMD_SET, 0, 32'hFFFF_FFFF, 0, 0);
    send_cmd(CMD_SET, 0, 5, 0, 0);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    send_cmd(CMD_PAUSE, 1, 0, 0, 0);
    send_cmd(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_QUERY, 1, 0, 0, 0);
    send_cmd(CMD_RESUME, 1, 0, 0, 0);
    send_cmd(CMD_RESET, 1, 0, 0, 0);
    send_cmd(CMD_QUERY, 1, 0, 0, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0, 0);
    // Fill to full, then two more sets.
    for (int i = 0; i < MaxTimers + 1; i++) send_cmd(CMD_SET, 0, i % 3, i % 2, 0);
    send_cmd(CMD_TICK, 0, 0, 0, 2);
    // The sender waits until every expected result is back.
    drain();
    send_cmd(CMD_CLEARALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);

    // Random: mostly sets and ticks on a live table, with a calm stretch.
    for (int i = 0; i < 100; i++) begin
      calm = (i >= 40 && i < 60);
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: send_cmd(CMD_SET, $urandom, pick_time(), $urandom_range(1),
                                   $urandom);
        6, 7, 8, 9, 10: send_cmd(CMD_TICK, $urandom, $urandom, $urandom_range(1),
                                 pick_time());
        11: send_cmd(CMD_CLEARALL, $urandom, $urandom, $urandom_range(1), $urandom);
        default: send_cmd(cmd_e'($urandom_range(1, 5)), pick_id(), $urandom,
                          $urandom_range(1), $urandom);
      endcase
    end
    calm = 1'b0;
    drain();
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("software_timer_table_top: match");
    end else begin
      $display("software_timer_table_top: mismatch");
    end
    $finish;
  end
endmodule
